// ===== hw/rtl/aspl_pkg.sv =====
// ----------------------------------------------------------------------------
// aspl_pkg: shared types and constants of the Annex B NAL splitter
// Holds the widths, queue sizing, unit-type codes and the records that
// travel from the byte parser through the result queue.
// ----------------------------------------------------------------------------
package aspl_pkg;

    // Width of the running stream byte position (offset arithmetic wraps here).
    localparam int POS_BITS      = 32;
    localparam int FIELD_W       = 32;

    // Result queue between the parser and the output stage.
    localparam int QUEUE_DEPTH   = 4;
    localparam int Q_PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int Q_LEVEL_W     = Q_PTR_W + 1;

    // NAL unit type codes that get a class of their own.
    localparam logic [4:0] TYPE_NON_IDR = 5'd1;
    localparam logic [4:0] TYPE_IDR     = 5'd5;
    localparam logic [4:0] TYPE_SEI     = 5'd6;
    localparam logic [4:0] TYPE_SPS     = 5'd7;
    localparam logic [4:0] TYPE_PPS     = 5'd8;

    // Class codes reported with each unit.
    localparam logic [2:0] CLS_UNKNOWN  = 3'd0;
    localparam logic [2:0] CLS_NON_IDR  = 3'd1;
    localparam logic [2:0] CLS_IDR      = 3'd2;
    localparam logic [2:0] CLS_SEI      = 3'd3;
    localparam logic [2:0] CLS_SPS      = 3'd4;
    localparam logic [2:0] CLS_PPS      = 3'd5;

    // Description of one closed unit, before the header byte is decoded.
    typedef struct packed {
        logic [FIELD_W-1:0] unit_index;
        logic [FIELD_W-1:0] start_offset;
        logic               long_code;
        logic [FIELD_W-1:0] length;
        logic [7:0]         header;
        logic               last;
    } t_unit_rec;

    // Write side of the queue: up to two records in one cycle, in order.
    typedef struct packed {
        logic [1:0] count;
        t_unit_rec  rec0;
        t_unit_rec  rec1;
    } t_q_wr;

    // Queue status seen by both the parser and the output stage.
    typedef struct packed {
        logic [Q_LEVEL_W-1:0] level;
        t_unit_rec            head;
    } t_q_stat;

endpackage

// ===== hw/rtl/aspl_if.sv =====
// ----------------------------------------------------------------------------
// aspl_byte_if / aspl_unit_if: channel interfaces of the NAL splitter
// Valid/ready channels for incoming stream bytes and outgoing unit results.
// ----------------------------------------------------------------------------
interface aspl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface aspl_unit_if;
    logic        valid;
    logic        ready;
    logic [31:0] unit_index;
    logic [31:0] start_offset;
    logic        long_start_code;
    logic [31:0] payload_length;
    logic        forbidden_bit;
    logic [1:0]  ref_priority;
    logic [4:0]  unit_type;
    logic [2:0]  type_class;
    logic        last_of_run;

    modport source (
        output valid, output unit_index, output start_offset, output long_start_code,
        output payload_length, output forbidden_bit, output ref_priority,
        output unit_type, output type_class, output last_of_run, input ready
    );
    modport sink (
        input valid, input unit_index, input start_offset, input long_start_code,
        input payload_length, input forbidden_bit, input ref_priority,
        input unit_type, input type_class, input last_of_run, output ready
    );
endinterface

// ===== hw/rtl/aspl_front.sv =====
// ----------------------------------------------------------------------------
// aspl_front: byte parser of the NAL splitter
// Tracks the last three bytes, finds start codes, keeps the open unit and
// pushes a record for every unit that closes into the result queue.
// ----------------------------------------------------------------------------
module aspl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aspl_byte_if.sink       i_byte,
    input  aspl_pkg::t_q_stat i_q_stat,
    output aspl_pkg::t_q_wr   o_q_wr
);
    import aspl_pkg::*;

    logic [23:0]         r_recent;
    logic [POS_BITS-1:0] r_pos;
    logic                r_open;
    logic [POS_BITS-1:0] r_off;
    logic                r_long;
    logic [FIELD_W-1:0]  r_cnt;
    logic [7:0]          r_hdr;
    logic [FIELD_W-1:0]  r_num;

    logic [POS_BITS-1:0] n_off;
    logic                n_open;
    logic                n_long;
    logic [FIELD_W-1:0]  n_cnt;
    logic [7:0]          n_hdr;
    logic [FIELD_W-1:0]  n_num;

    logic       accept;
    logic       sc;
    logic       lz;
    logic       emit0;
    logic       emit1;
    logic [7:0] b;
    t_unit_rec  rec0;
    t_unit_rec  rec1;

    // Two free slots are needed, since a start code on the final byte closes two units.
    assign i_byte.ready = (i_q_stat.level <= Q_LEVEL_W'(QUEUE_DEPTH - 2));
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.data_byte;

    assign sc    = (b == 8'h01) && (r_recent[7:0] == 8'h00) && (r_recent[15:8] == 8'h00);
    assign lz    = (r_recent[23:16] == 8'h00);
    assign emit0 = sc && r_open;

    // Unit state once this byte has been taken into account.
    always_comb begin
        n_open = r_open;
        n_long = r_long;
        n_off  = r_off;
        n_cnt  = r_cnt;
        n_hdr  = r_hdr;
        n_num  = r_num + FIELD_W'(emit0);
        if (sc) begin
            n_open = 1'b1;
            n_long = lz;
            n_off  = r_pos - (lz ? POS_BITS'(3) : POS_BITS'(2));
            n_cnt  = '0;
            n_hdr  = 8'h00;
        end else if (r_open) begin
            if (r_cnt == '0) begin
                n_hdr = b;
            end
            n_cnt = r_cnt + FIELD_W'(1);
        end
    end

    assign emit1 = i_byte.end_of_stream && n_open;

    always_comb begin
        rec0.unit_index   = r_num;
        rec0.start_offset = FIELD_W'(r_off);
        rec0.long_code    = r_long;
        rec0.length       = r_cnt - FIELD_W'(2) - FIELD_W'(lz);
        rec0.header       = r_hdr;
        rec0.last         = !emit1;

        rec1.unit_index   = n_num;
        rec1.start_offset = FIELD_W'(n_off);
        rec1.long_code    = n_long;
        rec1.length       = n_cnt;
        rec1.header       = n_hdr;
        rec1.last         = 1'b1;

        o_q_wr.count = 2'd0;
        o_q_wr.rec0  = rec0;
        o_q_wr.rec1  = rec1;
        if (accept) begin
            o_q_wr.count = {1'b0, emit0} + {1'b0, emit1};
            if (!emit0) begin
                o_q_wr.rec0 = rec1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= 24'hFFFFFF;
            r_pos    <= '0;
            r_open   <= 1'b0;
            r_off    <= '0;
            r_long   <= 1'b0;
            r_cnt    <= '0;
            r_hdr    <= 8'h00;
            r_num    <= FIELD_W'(1);
        end else if (accept) begin
            if (i_byte.end_of_stream) begin
                r_recent <= 24'hFFFFFF;
                r_pos    <= '0;
                r_open   <= 1'b0;
                r_off    <= '0;
                r_long   <= 1'b0;
                r_cnt    <= '0;
                r_hdr    <= 8'h00;
                r_num    <= FIELD_W'(1);
            end else begin
                r_recent <= {r_recent[15:0], b};
                r_pos    <= r_pos + POS_BITS'(1);
                r_open   <= n_open;
                r_off    <= n_off;
                r_long   <= n_long;
                r_cnt    <= n_cnt;
                r_hdr    <= n_hdr;
                r_num    <= n_num;
            end
        end
    end

endmodule

// ===== hw/rtl/aspl_queue.sv =====
// ----------------------------------------------------------------------------
// aspl_queue: result queue of the NAL splitter
// Small register queue that takes up to two unit records per cycle and
// hands out at most one per cycle to the output stage.
// ----------------------------------------------------------------------------
module aspl_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aspl_pkg::t_q_wr   i_q_wr,
    input  logic              i_pop,
    output aspl_pkg::t_q_stat o_q_stat
);
    import aspl_pkg::*;

    t_unit_rec            r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_LEVEL_W-1:0] r_level;

    logic [Q_PTR_W-1:0]   wr_next;

    assign wr_next = r_wr + Q_PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_q_wr.count != 2'd0) begin
            r_mem[r_wr] <= i_q_wr.rec0;
        end
        if (i_q_wr.count == 2'd2) begin
            r_mem[wr_next] <= i_q_wr.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= r_wr + Q_PTR_W'(i_q_wr.count);
            r_rd    <= r_rd + Q_PTR_W'(i_pop);
            r_level <= r_level + Q_LEVEL_W'(i_q_wr.count) - Q_LEVEL_W'(i_pop);
        end
    end

    assign o_q_stat.level = r_level;
    assign o_q_stat.head  = r_mem[r_rd];

endmodule

// ===== hw/rtl/aspl_back.sv =====
// ----------------------------------------------------------------------------
// aspl_back: output stage of the NAL splitter
// Takes one record from the queue, splits and classifies the header byte
// and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module aspl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aspl_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    aspl_unit_if.source       o_unit
);
    import aspl_pkg::*;

    logic               r_valid;
    logic [FIELD_W-1:0] r_index;
    logic [FIELD_W-1:0] r_offset;
    logic               r_long;
    logic [FIELD_W-1:0] r_length;
    logic [7:0]         r_header;
    logic [2:0]         r_class;
    logic               r_last;

    logic [2:0] n_class;
    t_unit_rec  head;

    assign head  = i_q_stat.head;
    assign o_pop = (i_q_stat.level != '0) && (!r_valid || o_unit.ready);

    always_comb begin
        case (head.header[4:0])
            TYPE_NON_IDR: n_class = CLS_NON_IDR;
            TYPE_IDR:     n_class = CLS_IDR;
            TYPE_SEI:     n_class = CLS_SEI;
            TYPE_SPS:     n_class = CLS_SPS;
            TYPE_PPS:     n_class = CLS_PPS;
            default:      n_class = CLS_UNKNOWN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_unit.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_index  <= head.unit_index;
            r_offset <= head.start_offset;
            r_long   <= head.long_code;
            r_length <= head.length;
            r_header <= head.header;
            r_class  <= n_class;
            r_last   <= head.last;
        end
    end

    assign o_unit.valid           = r_valid;
    assign o_unit.unit_index      = r_index;
    assign o_unit.start_offset    = r_offset;
    assign o_unit.long_start_code = r_long;
    assign o_unit.payload_length  = r_length;
    assign o_unit.forbidden_bit   = r_header[7];
    assign o_unit.ref_priority    = r_header[6:5];
    assign o_unit.unit_type       = r_header[4:0];
    assign o_unit.type_class      = r_class;
    assign o_unit.last_of_run     = r_last;

endmodule

// ===== hw/rtl/annexb_nal_splitter_core.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_splitter_core: H.264 Annex B start-code NAL unit splitter
// Scans an Annex B byte stream, finds 00 00 01 and 00 00 00 01 start codes
// and reports one result beat per NAL unit when the unit closes.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Beat contents
//  -------   ---   ----------------------------------------------------------
//  i_byte    in    data_byte, end_of_stream (one stream byte per beat)
//  o_unit    out   unit_index, start_offset, long_start_code, payload_length,
//                  forbidden_bit, ref_priority, unit_type, type_class,
//                  last_of_run (one closed unit per beat)
//
//  The parser takes one byte per clock; its start-code test and unit
//  bookkeeping finish in the cycle the byte is accepted.
//  A closed unit reaches o_unit through the result queue and then the output
//  register. The output side moves one unit per clock while ready is high.
//  Input stalls only while the four-entry queue has fewer than two free slots.
//  Reset (i_rst_n low at a clock edge) empties the queue and output register
//  and returns the parser to the start of a stream.
//
// ----------------------------------------------------------------------------
module annexb_nal_splitter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aspl_byte_if.sink   i_byte,
    aspl_unit_if.source o_unit
);
    import aspl_pkg::*;

    // The parser pushes records for units that close on the current byte.
    // A byte can close at most two units: a start code that is also the
    // final byte of the stream ends the previous unit and its own empty unit.
    t_q_wr   w_q_wr;
    t_q_stat w_q_stat;
    logic    w_pop;

    aspl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_stat (w_q_stat),
        .o_q_wr   (w_q_wr)
    );

    // The queue decouples the two sides so that a stalled consumer does not
    // hold up scanning until the queue is nearly full.
    aspl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_wr   (w_q_wr),
        .i_pop    (w_pop),
        .o_q_stat (w_q_stat)
    );

    // The output stage decodes the header byte and registers the result beat.
    aspl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_unit   (o_unit)
    );

`ifndef ASSERT_OFF
    // The queue never holds more records than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.level <= Q_LEVEL_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // The output stage only pops a record that is present.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_q_stat.level != '0))
        else $error("pop from empty result queue");

    // Whenever the parser pushes two records, the first is not a final one.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_wr.count == 2'd2) |-> (!w_q_wr.rec0.last && w_q_wr.rec1.last))
        else $error("two-unit push out of order");

    // Reset leaves no result beat on the output.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_unit.valid)
        else $error("result beat valid after reset");
`endif

endmodule
